@@ sv/tbpc_pkg.sv @@
// Shared types and constants for the timed blind position controller.
// No dependencies; used by the top level and the serial arithmetic units.
`default_nettype none

package tbpc_pkg;

  localparam int unsigned TimeW  = 16;           // hold_time, run_time, position, target
  localparam int unsigned LevelW = 18;           // signed Q16 level input
  localparam int unsigned OutW   = 17;           // Q16 level output, up to 65536
  localparam int unsigned SinceW = 17;           // ticks since start, saturating
  localparam int unsigned CfgIdxW = 4;

  localparam logic [TimeW-1:0]  HoldReset = 16'd200;
  localparam logic [TimeW-1:0]  RunReset  = 16'd1000;
  localparam logic [SinceW-1:0] SinceMax  = {SinceW{1'b1}};

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ROCKER  = 3'd1;
  localparam logic [2:0] OP_TRIGGER = 3'd2;
  localparam logic [2:0] OP_LEVEL   = 3'd3;
  localparam logic [2:0] OP_CLOSE   = 3'd4;

  localparam logic [1:0] BTN_RELEASED = 2'd0;
  localparam logic [1:0] BTN_UP       = 2'd1;

  localparam logic [CfgIdxW-1:0] REG_HOLD_TIME = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_RUN_TIME  = 4'd1;

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_UP   = 2'd1,
    MOT_DOWN = 2'd2
  } motion_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_APPLY,
    ST_DIV,
    ST_OUT
  } seq_state_e;

endpackage

`default_nettype wire

@@ sv/tbpc_serial_mul.sv @@
// Bit-serial unsigned multiplier: run_time times level magnitude, one bit per cycle.
// Uses tbpc_pkg for widths; returns the product shifted right by 16.
`default_nettype none

module tbpc_serial_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tbpc_pkg::TimeW-1:0]    mcand_i,
  input  wire logic [tbpc_pkg::LevelW-1:0]   mplier_i,
  output logic                               done_o,
  output logic [tbpc_pkg::LevelW-1:0]        prod_q16_o
);

  localparam int unsigned MW   = tbpc_pkg::LevelW;
  localparam int unsigned HW   = tbpc_pkg::TimeW + 1;
  localparam int unsigned CntW = $clog2(MW);
  localparam logic [CntW-1:0] CntLast = CntW'(MW - 1);

  logic [HW-1:0]   hi_q;
  logic [MW-1:0]   lo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [HW-1:0]   sum;

  assign sum = lo_q[0] ? (hi_q + {1'b0, mcand_i}) : hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // add on the low multiplier bit, then shift the accumulator pair right
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= mplier_i;
    end else if (busy_q) begin
      hi_q <= {1'b0, sum[HW-1:1]};
      lo_q <= {sum[0], lo_q[MW-1:1]};
    end
  end

  assign done_o     = done_q;
  assign prod_q16_o = {hi_q[HW-2:0], lo_q[MW-1:16]};

endmodule

`default_nettype wire

@@ sv/tbpc_serial_div.sv @@
// Restoring divider for the level output: position * 65536 / run_time.
// One quotient bit per cycle; uses tbpc_pkg for widths.
`default_nettype none

module tbpc_serial_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tbpc_pkg::TimeW-1:0]  pos_i,
  input  wire logic [tbpc_pkg::TimeW-1:0]  run_i,
  output logic                             done_o,
  output logic [tbpc_pkg::OutW-1:0]        quot_o
);

  localparam int unsigned W    = tbpc_pkg::TimeW;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

  logic [W-1:0]    rem_q;
  logic [W-1:0]    quot_q;
  logic [W-1:0]    div_q;
  logic            full_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [W:0]      rem2;
  logic            fits;

  assign rem2 = {rem_q, 1'b0};
  assign fits = (rem2 >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // position never exceeds run_time, so the remainder starts as position
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= pos_i;
      div_q  <= run_i;
      quot_q <= '0;
      full_q <= (pos_i == run_i);
    end else if (busy_q) begin
      rem_q  <= fits ? W'(rem2 - {1'b0, div_q}) : rem2[W-1:0];
      quot_q <= {quot_q[W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = full_q ? {1'b1, {W{1'b0}}} : {1'b0, quot_q};

endmodule

`default_nettype wire

@@ sv/timed_blind_position_controller.sv @@
// Timed blind position controller: run-time position estimate, buttons, level commands.
// Result path: an accepted word passes the state update and then the bit-serial divider;
// level commands first pass the bit-serial multiply of run_time by level.
// Input is stalled from acceptance until the result is loaded into the result register.
// Reset: hold_time 200, run_time 1000, position 500, target 0, stopped; no clearing pass.
// Depends on tbpc_pkg, tbpc_serial_mul and tbpc_serial_div.
`default_nettype none

module timed_blind_position_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input words
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [2:0]                      opcode_i,
  input  wire logic [1:0]                      button_i,
  input  wire logic                            level_mode_i,
  input  wire logic signed [tbpc_pkg::LevelW-1:0] level_i,
  input  wire logic                            close_enable_i,
  // result words
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [1:0]                           motion_o,
  output logic [tbpc_pkg::OutW-1:0]            level_out_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tbpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [tbpc_pkg::TimeW-1:0]      cfg_data_i
);

  localparam int unsigned TW = tbpc_pkg::TimeW;
  localparam int unsigned LW = tbpc_pkg::LevelW;

  tbpc_pkg::seq_state_e state_q, state_d;

  // registers and motion state
  logic [TW-1:0]                hold_q, run_q, pos_q, tgt_q;
  tbpc_pkg::motion_e            mst_q;
  logic                         up_q, dallow_q;
  logic [tbpc_pkg::SinceW-1:0]  since_q;

  // captured word
  logic [2:0]    op_q;
  logic [1:0]    btn_q;
  logic          mode_q, cen_q;
  logic [LW-1:0] lvl_q;

  // result register
  logic                      out_valid_q;
  logic [1:0]                out_motion_q;
  logic [tbpc_pkg::OutW-1:0] out_level_q;

  // next-state values from the update step
  logic [TW-1:0]               pos_n, tgt_n;
  tbpc_pkg::motion_e           mst_n;
  logic                        up_n, dallow_n;
  logic [tbpc_pkg::SinceW-1:0] since_n;

  logic          in_acc, out_load, cfg_wr;
  logic          mul_start, mul_done, div_start, div_done;
  logic [LW-1:0] lvl_mag, amag;
  logic [tbpc_pkg::OutW-1:0] quot;
  logic [19:0]   step_sum;
  logic [TW-1:0] run_wr;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign run_wr      = (cfg_data_i == '0) ? TW'(1) : cfg_data_i;

  assign lvl_mag   = level_i[LW-1] ? LW'(-level_i) : level_i;
  assign mul_start = in_acc && (opcode_i == tbpc_pkg::OP_LEVEL);
  assign div_start = (state_q == tbpc_pkg::ST_APPLY);

  tbpc_serial_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_start),
    .mcand_i    (run_q),
    .mplier_i   (lvl_mag),
    .done_o     (mul_done),
    .prod_q16_o (amag)
  );

  tbpc_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pos_i   (pos_n),
    .run_i   (run_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != tbpc_pkg::ST_IDLE);
    out_load   = 1'b0;
    unique case (state_q)
      tbpc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (opcode_i == tbpc_pkg::OP_LEVEL) ? tbpc_pkg::ST_MUL : tbpc_pkg::ST_APPLY;
        end
      end
      tbpc_pkg::ST_MUL: begin
        if (mul_done) state_d = tbpc_pkg::ST_APPLY;
      end
      tbpc_pkg::ST_APPLY: begin
        state_d = tbpc_pkg::ST_DIV;
      end
      tbpc_pkg::ST_DIV: begin
        if (div_done) state_d = tbpc_pkg::ST_OUT;
      end
      tbpc_pkg::ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = tbpc_pkg::ST_IDLE;
        end
      end
      default: state_d = tbpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // state update for one word
  always_comb begin
    pos_n    = pos_q;
    tgt_n    = tgt_q;
    mst_n    = mst_q;
    up_n     = up_q;
    dallow_n = dallow_q;
    since_n  = since_q;
    step_sum = {4'b0, tgt_q} + (lvl_q[LW-1] ? 20'(-{2'b0, amag}) : {2'b0, amag});

    unique case (op_q)
      tbpc_pkg::OP_TICK: begin
        if (since_q != tbpc_pkg::SinceMax) since_n = since_q + 1'b1;
        if (mst_q != tbpc_pkg::MOT_STOP) begin
          if (up_q) begin
            // snap to target once the step reaches or passes it
            pos_n = ({1'b0, pos_q} <= {1'b0, tgt_q} + 17'd1) ? tgt_q : pos_q - 1'b1;
          end else begin
            pos_n = ({1'b0, pos_q} + 17'd1 >= {1'b0, tgt_q}) ? tgt_q : pos_q + 1'b1;
          end
        end
      end
      tbpc_pkg::OP_ROCKER, tbpc_pkg::OP_TRIGGER: begin
        if (btn_q == tbpc_pkg::BTN_RELEASED) begin
          if (since_q > {1'b0, hold_q}) tgt_n = pos_q;
        end else if (mst_q == tbpc_pkg::MOT_STOP) begin
          if (op_q == tbpc_pkg::OP_TRIGGER) begin
            tgt_n = ((up_q || tgt_q == '0) && tgt_q < run_q) ? run_q : '0;
          end else if (btn_q == tbpc_pkg::BTN_UP) begin
            tgt_n = '0;
          end else begin
            tgt_n = run_q;
          end
        end else begin
          tgt_n = pos_q;
        end
      end
      tbpc_pkg::OP_LEVEL: begin
        if (!mode_q) begin
          if (lvl_q[LW-1]) tgt_n = '0;
          else if (amag > {2'b0, run_q}) tgt_n = run_q;
          else tgt_n = amag[TW-1:0];
        end else begin
          if (step_sum[19]) tgt_n = '0;
          else if (step_sum > {4'b0, run_q}) tgt_n = run_q;
          else tgt_n = step_sum[TW-1:0];
        end
      end
      tbpc_pkg::OP_CLOSE: begin
        dallow_n = cen_q;
      end
      default: ;
    endcase

    if (!dallow_n && tgt_n > pos_n) tgt_n = pos_n;

    if (pos_n == tgt_n) begin
      mst_n = tbpc_pkg::MOT_STOP;
    end else if (mst_q == tbpc_pkg::MOT_STOP) begin
      up_n    = (tgt_n < pos_n);
      mst_n   = up_n ? tbpc_pkg::MOT_UP : tbpc_pkg::MOT_DOWN;
      since_n = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= tbpc_pkg::HoldReset;
      run_q    <= tbpc_pkg::RunReset;
      pos_q    <= tbpc_pkg::RunReset >> 1;
      tgt_q    <= '0;
      mst_q    <= tbpc_pkg::MOT_STOP;
      up_q     <= 1'b0;
      dallow_q <= 1'b1;
      since_q  <= '0;
    end else if (cfg_wr) begin
      if (cfg_index_i == tbpc_pkg::REG_HOLD_TIME) begin
        hold_q <= cfg_data_i;
      end else if (cfg_index_i == tbpc_pkg::REG_RUN_TIME) begin
        // restart the motion estimate
        run_q    <= run_wr;
        pos_q    <= run_wr >> 1;
        tgt_q    <= '0;
        mst_q    <= tbpc_pkg::MOT_STOP;
        up_q     <= 1'b0;
        dallow_q <= 1'b1;
        since_q  <= '0;
      end
    end else if (state_q == tbpc_pkg::ST_APPLY) begin
      pos_q    <= pos_n;
      tgt_q    <= tgt_n;
      mst_q    <= mst_n;
      up_q     <= up_n;
      dallow_q <= dallow_n;
      since_q  <= since_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= opcode_i;
      btn_q  <= button_i;
      mode_q <= level_mode_i;
      lvl_q  <= level_i;
      cen_q  <= close_enable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_motion_q <= mst_q;
      out_level_q  <= quot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign motion_o    = out_motion_q;
  assign level_out_o = out_level_q;

endmodule

`default_nettype wire
